@@ design/unbiased_random_index_generator_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef UNBIASED_RANDOM_INDEX_GENERATOR_ASSERT_SVH
`define UNBIASED_RANDOM_INDEX_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define URIG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urig assertion failed");

// Next-cycle implication, disabled while reset is low.
`define URIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urig assertion failed");

`endif

@@ design/urig_pkg.sv @@
`timescale 1ns / 1ps

package urig_pkg;

    localparam int STATE_W = 64;
    localparam int COUNT_W = 32;

    localparam logic [STATE_W-1:0] ALL_ONES = {STATE_W{1'b1}};

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [STATE_W-1:0] seed_value;
    } urig_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] random_index;
        logic [STATE_W-1:0] raw_state;
    } urig_out_t;

    typedef struct packed {
        logic load_seed;
        logic load_count;
        logic start_limit;
        logic step;
        logic start_draw;
        logic store_limit;
        logic load_out;
    } urig_cmd_t;

    typedef struct packed {
        logic div_done;
        logic accept_ok;
        logic out_free;
    } urig_sts_t;

    function automatic logic [STATE_W-1:0] xorshift_step(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

@@ design/urig_divider.sv @@
`timescale 1ns / 1ps

module urig_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [urig_pkg::STATE_W-1:0] dividend,
    input  logic [urig_pkg::COUNT_W-1:0] divisor,
    output logic                         done,
    output logic [urig_pkg::COUNT_W-1:0] remainder
);
    import urig_pkg::*;

    localparam int CNT_W = $clog2(STATE_W);

    logic [STATE_W-1:0] q_reg, q_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [COUNT_W:0]   shifted;
    logic [COUNT_W-1:0] diff;
    logic               ge;

    // Restoring remainder, one dividend bit per cycle from the top.
    always_comb
    begin
        shifted   = {rem_reg, q_reg[STATE_W-1]};
        ge        = shifted >= {1'b0, d_reg};
        diff      = shifted[COUNT_W-1:0] - d_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[STATE_W-2:0], 1'b0};
            rem_next = ge ? diff : shifted[COUNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STATE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ design/urig_datapath.sv @@
`timescale 1ns / 1ps

module urig_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  urig_pkg::urig_cmd_t          cmd,
    output urig_pkg::urig_sts_t          sts,
    input  logic [urig_pkg::COUNT_W-1:0] cfg_data,
    input  logic [urig_pkg::STATE_W-1:0] seed_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output urig_pkg::urig_out_t          out_data
);
    import urig_pkg::*;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [STATE_W-1:0] limit_reg, limit_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    urig_out_t          out_data_reg, out_data_next;

    logic [STATE_W-1:0] adv;
    logic [COUNT_W-1:0] eff_count;
    logic               div_start;
    logic [STATE_W-1:0] div_dividend;
    logic [COUNT_W-1:0] div_divisor;
    logic               div_done;
    logic [COUNT_W-1:0] div_rem;

    // A count of zero behaves as a count of one.
    assign eff_count    = (cfg_data == '0) ? COUNT_W'(1) : cfg_data;
    assign adv          = xorshift_step(state_reg);
    assign div_start    = cmd.start_limit | cmd.start_draw;
    assign div_dividend = cmd.start_limit ? ALL_ONES : adv;
    assign div_divisor  = cmd.load_count ? eff_count : count_reg;

    urig_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.load_seed)
            state_next = seed_value;
        else if (cmd.step)
            state_next = adv;
        if (cmd.load_count)
            count_next = eff_count;
        if (cmd.store_limit)
            limit_next = ALL_ONES - {{(STATE_W-COUNT_W){1'b0}}, div_rem};
        if (cmd.load_out)
        begin
            out_valid_next             = 1'b1;
            out_data_next.random_index = div_rem;
            out_data_next.raw_state    = state_reg;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            limit_reg     <= ALL_ONES;
            count_reg     <= COUNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign sts.div_done  = div_done;
    assign sts.accept_ok = adv < limit_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

@@ design/urig_ctrl.sv @@
`timescale 1ns / 1ps

module urig_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  urig_pkg::urig_sts_t sts,
    output urig_pkg::urig_cmd_t cmd
);
    import urig_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LIMIT = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [2:0] state_reg, state_next;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.load_count  = 1'b1;
                    cmd.start_limit = 1'b1;
                    state_next      = S_LIMIT;
                end
                else if (in_valid)
                begin
                    if (req_type == REQ_DRAW)
                        state_next = S_STEP;
                    else
                        cmd.load_seed = 1'b1;
                end
            end
            S_LIMIT:
            begin
                if (sts.div_done)
                begin
                    cmd.store_limit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_STEP:
            begin
                // advance; retry while the state lands at or above the limit
                cmd.step = 1'b1;
                if (sts.accept_ok)
                begin
                    cmd.start_draw = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                        state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/unbiased_random_index_generator.sv @@
`timescale 1ns / 1ps

// Unbiased random index generator: a 64-bit xorshift state (13 left, 7 right,
// 17 left) drawn through rejection sampling and reduced modulo the count last
// written on cfg_data. A seed word loads the state and gives no output word. A
// draw word advances the state one xorshift step per cycle until it falls below
// the rejection limit, then takes the remainder on a shared divider that
// retires one dividend bit per cycle, so the output word of a draw appears once
// the divider is done and the output register is free, later with each
// rejection retry, and the next input word can be taken once the control is
// idle again. A write on cfg_data recomputes the limit on the same divider;
// input is held off until the limit is stored. A count of zero behaves as one.
// An output word that is not yet taken waits in its register while the next
// input word is accepted.
module unbiased_random_index_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [urig_pkg::COUNT_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  urig_pkg::urig_in_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output urig_pkg::urig_out_t          out_data
);
    import urig_pkg::*;

    urig_cmd_t cmd;
    urig_sts_t sts;

    urig_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (in_data.req_type),
        .sts       (sts),
        .cmd       (cmd)
    );

    urig_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_data   (cfg_data),
        .seed_value (in_data.seed_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

@@ design/urig_checker.sv @@
`timescale 1ns / 1ps

`include "unbiased_random_index_generator_assert.svh"

module urig_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                in_valid,
    input logic                in_ready,
    input urig_pkg::urig_in_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input urig_pkg::urig_out_t out_data
);
    import urig_pkg::*;

    // A waiting output word holds.
    `URIG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    // A count write keeps input off while the limit is rebuilt.
    `URIG_ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_valid && cfg_ready, !in_ready)
    // A draw cannot finish in the next cycle.
    `URIG_ASSERT_NEXT(a_draw_busy, clk, rst_n, in_valid && in_ready && in_data.req_type == REQ_DRAW, !in_ready)
    // A zero state always maps to index zero.
    `URIG_ASSERT_NOW(a_zero_idx, clk, rst_n, out_valid && out_data.raw_state == '0, out_data.random_index == '0)
    // Input is only taken when the count port is open too.
    `URIG_ASSERT_NOW(a_ready_order, clk, rst_n, in_ready, cfg_ready)

endmodule

bind unbiased_random_index_generator urig_checker u_urig_checker (.*);
